// ----- hw/rtl/afr_pkg.sv -----
// Shared types and constants of the audio frame fragmenter.
package afr_pkg;

  localparam int HDR_LEN = 17;
  localparam int HDR_IDX_W = 5;

  localparam logic [7:0] START_CODE_0 = 8'h00;
  localparam logic [7:0] START_CODE_1 = 8'h00;
  localparam logic [7:0] START_CODE_2 = 8'h01;
  localparam logic [7:0] START_CODE_3 = 8'hFC;
  localparam logic [7:0] FRAME_TYPE = 8'h00;

  localparam logic [HDR_IDX_W-1:0] IDX_SC1 = 5'd1;
  localparam logic [HDR_IDX_W-1:0] IDX_SC2 = 5'd2;
  localparam logic [HDR_IDX_W-1:0] IDX_SC3 = 5'd3;
  localparam logic [HDR_IDX_W-1:0] IDX_SIZE0 = 5'd4;
  localparam logic [HDR_IDX_W-1:0] IDX_SIZE1 = 5'd5;
  localparam logic [HDR_IDX_W-1:0] IDX_SIZE2 = 5'd6;
  localparam logic [HDR_IDX_W-1:0] IDX_SIZE3 = 5'd7;
  localparam logic [HDR_IDX_W-1:0] IDX_TS0 = 5'd8;
  localparam logic [HDR_IDX_W-1:0] IDX_TS1 = 5'd9;
  localparam logic [HDR_IDX_W-1:0] IDX_TS2 = 5'd10;
  localparam logic [HDR_IDX_W-1:0] IDX_TS3 = 5'd11;
  localparam logic [HDR_IDX_W-1:0] IDX_CNT0 = 5'd12;
  localparam logic [HDR_IDX_W-1:0] IDX_CNT1 = 5'd13;
  localparam logic [HDR_IDX_W-1:0] IDX_CNT2 = 5'd14;
  localparam logic [HDR_IDX_W-1:0] IDX_CNT3 = 5'd15;
  localparam logic [HDR_IDX_W-1:0] IDX_TYPE = 5'd16;
  localparam logic [HDR_IDX_W-1:0] IDX_DATA = 5'd17;

  typedef logic [HDR_IDX_W-1:0] hdr_idx_t;

  typedef struct packed {
    logic [31:0] size;
    logic [31:0] timestamp;
    logic [31:0] frame_num;
  } hdr_fields_t;

endpackage

// ----- hw/rtl/audio_frame_fragmenter_unit.sv -----
// Top level of the audio frame fragmenter: header insertion and packet marking.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_ready, in_audio_byte, in_frame_first,
//           |           | in_frame_size, in_timestamp_ms
//   out     | output    | out_valid, out_ready, out_byte, out_packet_start,
//           |           | out_packet_end, out_is_header
//
// A data byte is accepted every cycle unless a header burst or output stall holds it off,
// and shows in the output register in the next cycle. A frame start with data yields
// 18 items from the header counter; the input is held off until the burst has ended.
// Items that yield nothing (zero-size frames, stray bytes) give no output item.
// Reset is synchronous and clears the frame counter, byte and room counts.
// A stalled output holds the result register and the input waits with it.
module audio_frame_fragmenter_unit #(
  parameter int PACKET_MAX      = 1510,
  parameter int LINK_HEADER_LEN = 60,
  parameter int MAX_FRAME       = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_audio_byte,
  input  logic        in_frame_first,
  input  logic [11:0] in_frame_size,
  input  logic [31:0] in_timestamp_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_packet_start,
  output logic        out_packet_end,
  output logic        out_is_header
);

  localparam int FIRST_ROOM = PACKET_MAX - LINK_HEADER_LEN - afr_pkg::HDR_LEN;
  localparam int LATER_ROOM = PACKET_MAX - LINK_HEADER_LEN;
  localparam int ROOM_W = $clog2(LATER_ROOM + 1);
  localparam logic [16:0] MAX_FRAME_W = 17'(MAX_FRAME);

  logic [31:0]       frame_counter_r, frame_counter_nxt;
  logic [11:0]       bytes_remaining_r, bytes_remaining_nxt;
  logic [ROOM_W-1:0] packet_room_r, packet_room_nxt;
  logic              hdr_busy_r, hdr_busy_nxt;
  afr_pkg::hdr_idx_t hdr_idx_r, hdr_idx_nxt;
  logic [11:0]       hdr_size_r, hdr_size_nxt;
  logic [31:0]       hdr_ts_r, hdr_ts_nxt;
  logic [7:0]        pend_byte_r, pend_byte_nxt;
  logic              pend_end_r, pend_end_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_start_r, out_start_nxt;
  logic              out_end_r, out_end_nxt;
  logic              out_hdr_r, out_hdr_nxt;

  logic              take_out;
  logic              in_fire;
  logic [11:0]       size_sat;
  logic [11:0]       rem_base;
  logic [11:0]       rem_dec;
  logic [ROOM_W-1:0] room_base;
  logic [ROOM_W-1:0] room_dec;
  logic              start_new;
  logic              has_data;
  logic              data_end;
  logic [7:0]        hdr_byte;
  afr_pkg::hdr_fields_t hdr_fields;

  assign take_out = !out_valid_r || out_ready;
  assign in_ready = !hdr_busy_r && take_out;
  assign in_fire  = in_valid && in_ready;

  assign size_sat = ({5'd0, in_frame_size} > MAX_FRAME_W) ? MAX_FRAME_W[11:0] : in_frame_size;

  always_comb begin
    rem_base  = in_frame_first ? size_sat : bytes_remaining_r;
    start_new = !in_frame_first && (packet_room_r == '0);
    if (in_frame_first) begin
      room_base = ROOM_W'(FIRST_ROOM);
    end else if (start_new) begin
      room_base = ROOM_W'(LATER_ROOM);
    end else begin
      room_base = packet_room_r;
    end
    has_data = (rem_base != 12'd0);
    rem_dec  = rem_base - 12'd1;
    room_dec = room_base - ROOM_W'(1);
    data_end = (rem_dec == 12'd0) || (room_dec == '0);
  end

  assign hdr_fields.size      = {20'd0, hdr_size_r};
  assign hdr_fields.timestamp = hdr_ts_r;
  assign hdr_fields.frame_num = frame_counter_r;

  afr_hdr_sel u_hdr_sel (
    .idx      (hdr_idx_r),
    .fields   (hdr_fields),
    .hdr_byte (hdr_byte)
  );

  always_comb begin
    frame_counter_nxt   = frame_counter_r;
    bytes_remaining_nxt = bytes_remaining_r;
    packet_room_nxt     = packet_room_r;
    hdr_busy_nxt        = hdr_busy_r;
    hdr_idx_nxt         = hdr_idx_r;
    hdr_size_nxt        = hdr_size_r;
    hdr_ts_nxt          = hdr_ts_r;
    pend_byte_nxt       = pend_byte_r;
    pend_end_nxt        = pend_end_r;
    out_valid_nxt       = out_valid_r;
    out_byte_nxt        = out_byte_r;
    out_start_nxt       = out_start_r;
    out_end_nxt         = out_end_r;
    out_hdr_nxt         = out_hdr_r;

    if (in_fire) begin
      if (in_frame_first) begin
        frame_counter_nxt = frame_counter_r + 32'd1;
      end
      if (has_data) begin
        bytes_remaining_nxt = rem_dec;
        packet_room_nxt     = (rem_dec == 12'd0) ? '0 : room_dec;
      end else if (in_frame_first) begin
        bytes_remaining_nxt = 12'd0;
        packet_room_nxt     = '0;
      end
      out_valid_nxt = has_data;
      if (in_frame_first) begin
        hdr_busy_nxt  = has_data;
        hdr_idx_nxt   = afr_pkg::IDX_SC1;
        hdr_size_nxt  = size_sat;
        hdr_ts_nxt    = in_timestamp_ms;
        pend_byte_nxt = in_audio_byte;
        pend_end_nxt  = data_end;
        out_byte_nxt  = afr_pkg::START_CODE_0;
        out_start_nxt = 1'b1;
        out_end_nxt   = 1'b0;
        out_hdr_nxt   = 1'b1;
      end else begin
        out_byte_nxt  = in_audio_byte;
        out_start_nxt = start_new;
        out_end_nxt   = data_end;
        out_hdr_nxt   = 1'b0;
      end
    end else if (hdr_busy_r && take_out) begin
      out_valid_nxt = 1'b1;
      if (hdr_idx_r == afr_pkg::IDX_DATA) begin
        hdr_busy_nxt  = 1'b0;
        out_byte_nxt  = pend_byte_r;
        out_start_nxt = 1'b0;
        out_end_nxt   = pend_end_r;
        out_hdr_nxt   = 1'b0;
      end else begin
        hdr_idx_nxt   = hdr_idx_r + afr_pkg::hdr_idx_t'(1);
        out_byte_nxt  = hdr_byte;
        out_start_nxt = 1'b0;
        out_end_nxt   = 1'b0;
        out_hdr_nxt   = 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_counter_r   <= 32'd0;
      bytes_remaining_r <= 12'd0;
      packet_room_r     <= '0;
      hdr_busy_r        <= 1'b0;
      hdr_idx_r         <= afr_pkg::IDX_SC1;
      out_valid_r       <= 1'b0;
    end else begin
      frame_counter_r   <= frame_counter_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
      packet_room_r     <= packet_room_nxt;
      hdr_busy_r        <= hdr_busy_nxt;
      hdr_idx_r         <= hdr_idx_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_size_r  <= hdr_size_nxt;
    hdr_ts_r    <= hdr_ts_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_end_r  <= pend_end_nxt;
    out_byte_r  <= out_byte_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    out_hdr_r   <= out_hdr_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_packet_start = out_start_r;
  assign out_packet_end   = out_end_r;
  assign out_is_header    = out_hdr_r;

`ifndef SYNTHESIS
  a_hdr_never_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hdr_r && out_end_r))
    else $error("header item marked as packet end");

  a_frame_opens_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_frame_first && has_data) |=> (out_valid_r && out_hdr_r && out_start_r))
    else $error("frame start did not open a packet with a header item");

  a_burst_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_busy_r |-> out_valid_r)
    else $error("header burst active without a pending output item");
`endif

endmodule

// ----- hw/rtl/afr_hdr_sel.sv -----
// Selects one byte of the frame header by its position.
module afr_hdr_sel (
  input  afr_pkg::hdr_idx_t    idx,
  input  afr_pkg::hdr_fields_t fields,
  output logic [7:0]           hdr_byte
);

  always_comb begin
    unique case (idx)
      afr_pkg::IDX_SC1:   hdr_byte = afr_pkg::START_CODE_1;
      afr_pkg::IDX_SC2:   hdr_byte = afr_pkg::START_CODE_2;
      afr_pkg::IDX_SC3:   hdr_byte = afr_pkg::START_CODE_3;
      afr_pkg::IDX_SIZE0: hdr_byte = fields.size[31:24];
      afr_pkg::IDX_SIZE1: hdr_byte = fields.size[23:16];
      afr_pkg::IDX_SIZE2: hdr_byte = fields.size[15:8];
      afr_pkg::IDX_SIZE3: hdr_byte = fields.size[7:0];
      afr_pkg::IDX_TS0:   hdr_byte = fields.timestamp[31:24];
      afr_pkg::IDX_TS1:   hdr_byte = fields.timestamp[23:16];
      afr_pkg::IDX_TS2:   hdr_byte = fields.timestamp[15:8];
      afr_pkg::IDX_TS3:   hdr_byte = fields.timestamp[7:0];
      afr_pkg::IDX_CNT0:  hdr_byte = fields.frame_num[31:24];
      afr_pkg::IDX_CNT1:  hdr_byte = fields.frame_num[23:16];
      afr_pkg::IDX_CNT2:  hdr_byte = fields.frame_num[15:8];
      afr_pkg::IDX_CNT3:  hdr_byte = fields.frame_num[7:0];
      afr_pkg::IDX_TYPE:  hdr_byte = afr_pkg::FRAME_TYPE;
      default:            hdr_byte = afr_pkg::START_CODE_0;
    endcase
  end

endmodule
